// ----- rtl/tss_pkg.sv -----
package tss_pkg;

    // Store geometry
    localparam int NUM_STACKS  = 3;
    localparam int STACK_DEPTH = 16;
    localparam int STORE_WORDS = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int SEL_W       = 2;

    // Field widths
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int OUT_CNT_W   = 5;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Capacity register reset value
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    // Classified operation handed from the front to the back
    typedef struct packed {
        status_t             status;
        logic                do_write;
        logic                do_read;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   value;
        logic [CNT_W-1:0]    count_after;
    } op_t;

    // Result waiting for the RAM read data
    typedef struct packed {
        status_t             status;
        logic                use_rdata;
        logic [CNT_W-1:0]    count_after;
    } pend_t;

endpackage

// ----- rtl/tss_ram.sv -----
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tss_front.sv -----
module tss_front (
    input  logic                          clk,
    input  logic                          rst_n,
    // item input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [tss_pkg::SEL_W-1:0]     stack_select,
    input  logic [tss_pkg::DATA_W-1:0]    push_value,
    // capacity register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tss_pkg::CAP_W-1:0]     cfg_data,
    // to the queue
    output logic                          op_valid,
    input  logic                          op_ready,
    output tss_pkg::op_t                  op
);

    logic [tss_pkg::CAP_W-1:0] cap_reg;
    logic [tss_pkg::CNT_W-1:0] counts_reg [tss_pkg::NUM_STACKS];

    logic                      accept;
    logic                      sel_ok;
    logic [tss_pkg::CNT_W-1:0] cap_eff;
    logic [tss_pkg::CNT_W-1:0] cnt;
    logic [tss_pkg::CNT_W-1:0] cnt_next;
    logic [tss_pkg::CNT_W-1:0] pos;
    logic [tss_pkg::ADDR_W-1:0] base;

    assign cfg_ready = 1'b1;
    assign in_ready  = op_ready;
    assign op_valid  = in_valid;
    assign accept    = in_valid && op_ready;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= tss_pkg::CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Effective capacity, clamped to the slice depth
    always_comb
    begin
        if (int'(cap_reg) > tss_pkg::STACK_DEPTH)
        begin
            cap_eff = tss_pkg::CNT_W'(tss_pkg::STACK_DEPTH);
        end
        else
        begin
            cap_eff = tss_pkg::CNT_W'(cap_reg);
        end
    end

    // Classify the item and compute the slot address
    always_comb
    begin
        sel_ok         = int'(stack_select) < tss_pkg::NUM_STACKS;
        cnt            = sel_ok ? counts_reg[stack_select] : '0;
        cnt_next       = cnt;
        pos            = cnt;
        op.status      = tss_pkg::ST_OK;
        op.do_write    = 1'b0;
        op.do_read     = 1'b0;
        op.value       = push_value;
        if (!sel_ok)
        begin
            op.status = tss_pkg::ST_INVALID;
        end
        else if (kind == tss_pkg::KIND_PUSH)
        begin
            if (cnt >= cap_eff)
            begin
                op.status = tss_pkg::ST_FULL;
            end
            else
            begin
                op.do_write = 1'b1;
                cnt_next    = cnt + 1'b1;
            end
        end
        else
        begin
            if (cnt == '0)
            begin
                op.status = tss_pkg::ST_EMPTY;
            end
            else
            begin
                op.do_read = 1'b1;
                cnt_next   = cnt - 1'b1;
                pos        = cnt - 1'b1;
            end
        end
        // small multiply: stack select (0..3, only 0..2 valid) by capacity
        base           = tss_pkg::ADDR_W'(stack_select) * tss_pkg::ADDR_W'(cap_eff);
        op.addr        = base + tss_pkg::ADDR_W'(pos);
        op.count_after = cnt_next;
    end

    // Occupancy counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tss_pkg::NUM_STACKS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (accept && sel_ok)
        begin
            counts_reg[stack_select] <= cnt_next;
        end
    end

endmodule

// ----- rtl/tss_queue.sv -----
module tss_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  tss_pkg::op_t  wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output tss_pkg::op_t  rd_op
);

    tss_pkg::op_t                entry_reg [tss_pkg::QUEUE_DEPTH];
    logic [tss_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [tss_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [tss_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [tss_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [tss_pkg::QCNT_W-1:0]  fill_reg;
    logic [tss_pkg::QCNT_W-1:0]  fill_next;
    logic                        do_wr;
    logic                        do_rd;

    assign wr_ready = int'(fill_reg) < tss_pkg::QUEUE_DEPTH;
    assign rd_valid = fill_reg != '0;
    assign rd_op    = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == tss_pkg::QUEUE_DEPTH - 1) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == tss_pkg::QUEUE_DEPTH - 1) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// ----- rtl/tss_back.sv -----
module tss_back (
    input  logic                              clk,
    input  logic                              rst_n,
    // from the queue
    input  logic                              op_valid,
    output logic                              op_ready,
    input  tss_pkg::op_t                      op,
    // result output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [tss_pkg::DATA_W-1:0]        pop_value,
    output logic [tss_pkg::OUT_CNT_W-1:0]     count_after
);

    logic                              pend_valid_reg;
    logic                              pend_valid_next;
    tss_pkg::pend_t                    pend_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    tss_pkg::status_t                  out_status_reg;
    logic [tss_pkg::DATA_W-1:0]        out_pop_reg;
    logic [tss_pkg::OUT_CNT_W-1:0]     out_count_reg;
    logic                              out_load;
    logic                              deq;
    logic [tss_pkg::DATA_W-1:0]        rdata;

    // Advance the pending slot into the output register, then refill it
    assign out_load = pend_valid_reg && (!out_valid_reg || out_ready);
    assign deq      = op_valid && (!pend_valid_reg || out_load);
    assign op_ready = !pend_valid_reg || out_load;

    // Store access, one operation per cycle unless the pending slot is held, in item order
    tss_ram #(
        .WIDTH (tss_pkg::DATA_W),
        .DEPTH (tss_pkg::STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (deq && op.do_write),
        .waddr (op.addr),
        .wdata (op.value),
        .re    (deq && op.do_read),
        .raddr (op.addr),
        .rdata (rdata)
    );

    // Valid flags
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (deq)
        begin
            pend_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (deq)
        begin
            pend_reg.status      <= op.status;
            pend_reg.use_rdata   <= op.do_read;
            pend_reg.count_after <= op.count_after;
        end
        if (out_load)
        begin
            out_status_reg <= pend_reg.status;
            out_pop_reg    <= pend_reg.use_rdata ? rdata : '0;
            out_count_reg  <= tss_pkg::OUT_CNT_W'(pend_reg.count_after);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign pop_value   = out_pop_reg;
    assign count_after = out_count_reg;

endmodule

// ----- rtl/three_stacks_shared_store_core.sv -----
// Three LIFO stacks in one shared 48-word store, each with an equal slice.
//
// Input channel (in_valid/in_ready): kind (0 push, 1 pop), stack_select
// (0..2, 3 is invalid) and push_value. Every item gives exactly one result
// on the output channel (out_valid/out_ready): status, pop_value and
// count_after, in item order.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the capacity
// shared by every stack; it is always ready and should only be written while idle.
//
// Path: queue entry, then pending slot with the store access, then output register.
// Throughput: one item per cycle while out_ready is high; the front updates
// a counter and the back does one store access (one write or one registered
// read) per item. A two-entry queue sits between front and back.
//
// Reset clears the counters (all stacks empty), sets capacity to 16 and
// empties the queue and output. Store contents are not cleared.
// When out_ready is low the result holds in the output register, one more
// in the pending slot, then the queue fills and in_ready drops.
module three_stacks_shared_store_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [1:0]                        stack_select,
    input  logic signed [31:0]                push_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic signed [31:0]                pop_value,
    output logic [4:0]                        count_after,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [4:0]                        cfg_data
);

    logic          f_valid;
    logic          f_ready;
    tss_pkg::op_t  f_op;
    logic          b_valid;
    logic          b_ready;
    tss_pkg::op_t  b_op;

    // Accept and classify
    tss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .stack_select (stack_select),
        .push_value   (push_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .op_valid     (f_valid),
        .op_ready     (f_ready),
        .op           (f_op)
    );

    // Decoupling queue
    tss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_op    (f_op),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_op    (b_op)
    );

    // Store access and result output
    tss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (b_valid),
        .op_ready    (b_ready),
        .op          (b_op),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .pop_value   (pop_value),
        .count_after (count_after)
    );

endmodule

// ----- rtl/tss_checker.sv -----
module tss_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [1:0]   status,
    input  logic [31:0]  pop_value,
    input  logic [4:0]   count_after
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(pop_value) && $stable(count_after))
        else $error("result changed while stalled");

    // Only a successful pop carries a value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != tss_pkg::ST_OK |-> pop_value == '0)
        else $error("failed item carries a pop value");

    // Invalid stack and empty stack both report zero occupancy
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tss_pkg::ST_INVALID || status == tss_pkg::ST_EMPTY)
            |-> count_after == '0)
        else $error("nonzero count on invalid or empty status");

    // Occupancy never exceeds a slice
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(count_after) <= tss_pkg::STACK_DEPTH)
        else $error("count above stack depth");

endmodule

bind three_stacks_shared_store_core tss_checker u_tss_checker (.*);
